>>> rtl/rpap_pkg.sv
// ----------------------------------------------------------------------------
// Rotate point about pivot: shared package
// Types, constants and the arctangent table used by the CORDIC cell chains.
// ----------------------------------------------------------------------------
package rpap_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int FRACTION_BITS = 16;
    localparam int GUARD_BITS    = 4;
    localparam int DW            = 40;   // CORDIC datapath width, Q16.20 plus headroom
    localparam int ZW            = 34;   // signed residual angle width in the rotation chain
    localparam int SW            = 5;    // stage index width

    localparam logic [30:0] TURN_SCALE      = 31'd683565276;
    localparam logic [22:0] INV_GAIN_SQ_Q24 = 23'd6186701;
    localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN       = 32'h8000_0000;
    localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

    typedef struct packed {
        logic signed [31:0] pivot_u;
        logic signed [31:0] pivot_v;
        logic signed [31:0] point_u_in;
        logic signed [31:0] point_v_in;
        logic signed [19:0] turn_angle;
    } t_req;

    typedef struct packed {
        logic signed [31:0] point_u_out;
        logic signed [31:0] point_v_out;
        logic               saturated;
    } t_rsp;

    // Payload travelling down the vectoring chain.
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic [31:0]          z;
        logic                 coincident;
        logic                 vertical;
        logic                 dv_pos;
        logic [31:0]          turn_bin;
        logic signed [31:0]   pu;
        logic signed [31:0]   pv;
    } t_vec;

    // Payload travelling down the rotation chain.
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] zs;
        logic signed [31:0]   pu;
        logic signed [31:0]   pv;
    } t_rot;

    // Arctangent of 2^-i as a binary angle (2^32 units per turn).
    function automatic logic [31:0] atan_bin(input logic [SW-1:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/rpap_vec_cell.sv
// ----------------------------------------------------------------------------
// Rotate point about pivot: vectoring CORDIC cell
// One registered micro-rotation that drives y toward zero and sums the angle.
// ----------------------------------------------------------------------------
module rpap_vec_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [rpap_pkg::SW-1:0] i_stage,
    input  logic             i_valid,
    input  rpap_pkg::t_vec   i_data,
    output logic             o_valid,
    output rpap_pkg::t_vec   o_data
);
    import rpap_pkg::*;

    logic r_valid;
    t_vec r_data;
    t_vec n_data;

    always_comb begin
        n_data = i_data;
        if (!i_data.y[DW-1]) begin
            n_data.x = i_data.x + (i_data.y >>> i_stage);
            n_data.y = i_data.y - (i_data.x >>> i_stage);
            n_data.z = i_data.z + atan_bin(i_stage);
        end else begin
            n_data.x = i_data.x - (i_data.y >>> i_stage);
            n_data.y = i_data.y + (i_data.x >>> i_stage);
            n_data.z = i_data.z - atan_bin(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/rpap_rot_cell.sv
// ----------------------------------------------------------------------------
// Rotate point about pivot: rotation CORDIC cell
// One registered micro-rotation that turns the vector toward the target angle.
// ----------------------------------------------------------------------------
module rpap_rot_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [rpap_pkg::SW-1:0] i_stage,
    input  logic             i_valid,
    input  rpap_pkg::t_rot   i_data,
    output logic             o_valid,
    output rpap_pkg::t_rot   o_data
);
    import rpap_pkg::*;

    logic r_valid;
    t_rot r_data;
    t_rot n_data;
    logic signed [ZW-1:0] atan_s;

    always_comb begin
        atan_s = signed'({{(ZW-32){1'b0}}, atan_bin(i_stage)});
        n_data = i_data;
        if (!i_data.zs[ZW-1]) begin
            n_data.x  = i_data.x - (i_data.y >>> i_stage);
            n_data.y  = i_data.y + (i_data.x >>> i_stage);
            n_data.zs = i_data.zs - atan_s;
        end else begin
            n_data.x  = i_data.x + (i_data.y >>> i_stage);
            n_data.y  = i_data.y - (i_data.x >>> i_stage);
            n_data.zs = i_data.zs + atan_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/rotate_point_about_pivot_unit.sv
// ----------------------------------------------------------------------------
// Rotate point about pivot: top level
// Rotates a Q16.16 point about a pivot by a Q4.16 radian angle with two
// pipelined CORDIC cell chains, saturating the result.
// ----------------------------------------------------------------------------
// The unit accepts one request per clock cycle while the output is not stalled
// and returns exactly one response per request, in order. Its stages are one
// input stage, 24 vectoring cells that find the distance and polar angle of
// the point from the pivot, two stages that pick the polar angle, add the turn
// and remove the CORDIC gain, 24 rotation cells that place the point at the
// new angle, and the output register. The whole pipeline moves as one; it
// advances whenever the output register is empty or its response is being
// taken, so a stalled response holds every stage.
// The coincidence tolerance register resets to 66 and is written through the
// configuration channel, which is always ready.
module rotate_point_about_pivot_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  rpap_pkg::t_req   i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output rpap_pkg::t_rsp   o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [15:0]      i_cfg_data
);
    import rpap_pkg::*;

    logic        pipe_en;
    logic [15:0] r_tol;

    // Input stage.
    logic r_s0_valid;
    t_vec r_s0;
    t_vec n_s0;
    logic signed [33:0] du;
    logic signed [33:0] dv;
    logic signed [33:0] adu;
    logic signed [33:0] adv;
    logic signed [33:0] tol_s;
    logic signed [DW-1:0] x0;
    logic signed [DW-1:0] y0;
    logic signed [50:0] turn_prod;
    logic signed [50:0] turn_round;

    // Vectoring chain.
    logic vec_valid [CORDIC_STAGES+1];
    t_vec vec_data  [CORDIC_STAGES+1];

    // Angle select and gain stages.
    logic        r_c_valid;
    logic [42:0] r_c_phi_hi;
    logic [42:0] r_c_plo;
    logic        r_c_flip;
    logic signed [ZW-1:0] r_c_zs;
    logic signed [31:0] r_c_pu;
    logic signed [31:0] r_c_pv;
    t_vec        vec_last;
    logic [31:0] polar;
    logic [31:0] phi;
    logic [31:0] phi_fix;
    logic        flip;

    logic        r_g_valid;
    t_rot        r_g;
    logic [63:0] gain_sum;
    logic signed [DW-1:0] gx;

    // Rotation chain.
    logic rot_valid [CORDIC_STAGES+1];
    t_rot rot_data  [CORDIC_STAGES+1];

    // Output register.
    logic r_out_valid;
    t_rsp r_out;
    t_rsp n_out;
    t_rot rot_last;
    logic signed [DW-1:0] xr;
    logic signed [DW-1:0] yr;
    logic signed [36:0] su;
    logic signed [36:0] sv;
    logic        sat_u;
    logic        sat_v;

    assign pipe_en     = !r_out_valid || i_rsp_ready;
    assign o_req_ready = pipe_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 16'd66;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    // The differences are exact in 34 bits; the vectoring chain starts in the
    // right half plane, with a half turn preloaded when the point lies left.
    always_comb begin
        du    = 34'(i_req.point_u_in) - 34'(i_req.pivot_u);
        dv    = 34'(i_req.point_v_in) - 34'(i_req.pivot_v);
        adu   = du[33] ? -du : du;
        adv   = dv[33] ? -dv : dv;
        tol_s = signed'({18'd0, r_tol});
        x0    = DW'(du) <<< GUARD_BITS;
        y0    = DW'(dv) <<< GUARD_BITS;
        turn_prod  = 51'(i_req.turn_angle) * signed'({20'd0, TURN_SCALE});
        turn_round = turn_prod + 51'(signed'(52'd1 <<< (FRACTION_BITS - 1)));

        n_s0.x          = du[33] ? -x0 : x0;
        n_s0.y          = du[33] ? -y0 : y0;
        n_s0.z          = du[33] ? HALF_TURN : 32'd0;
        n_s0.coincident = (adu <= tol_s) && (adv <= tol_s);
        n_s0.vertical   = (adu <= tol_s);
        n_s0.dv_pos     = !dv[33] && (dv != 34'sd0);
        n_s0.turn_bin   = 32'(turn_round >>> FRACTION_BITS);
        n_s0.pu         = i_req.pivot_u;
        n_s0.pv         = i_req.pivot_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s0_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s0 <= n_s0;
        end
    end

    assign vec_valid[0] = r_s0_valid;
    assign vec_data[0]  = r_s0;

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec
        rpap_vec_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_stage (SW'(gi)),
            .i_valid (vec_valid[gi]),
            .i_data  (vec_data[gi]),
            .o_valid (vec_valid[gi+1]),
            .o_data  (vec_data[gi+1])
        );
    end

    // Pick the polar angle, add the turn, fold the target angle into the
    // right half plane, and start the gain multiply as two partial products.
    always_comb begin
        vec_last = vec_data[CORDIC_STAGES];
        if (vec_last.coincident) begin
            polar = 32'd0;
        end else if (vec_last.vertical) begin
            polar = vec_last.dv_pos ? QUARTER_TURN : THREE_QUARTER_TURN;
        end else begin
            polar = vec_last.z;
        end
        phi     = polar + vec_last.turn_bin;
        flip    = |((phi + QUARTER_TURN) & HALF_TURN);
        phi_fix = flip ? (phi - HALF_TURN) : phi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else if (pipe_en) begin
            r_c_valid <= vec_valid[CORDIC_STAGES];
            r_g_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_c_phi_hi <= 43'(vec_last.x[DW-1:20]) * 43'(INV_GAIN_SQ_Q24);
            r_c_plo    <= 43'(vec_last.x[19:0]) * 43'(INV_GAIN_SQ_Q24);
            r_c_flip   <= flip;
            r_c_zs     <= ZW'(signed'(phi_fix));
            r_c_pu     <= vec_last.pu;
            r_c_pv     <= vec_last.pv;
        end
    end

    always_comb begin
        gain_sum = {r_c_phi_hi, 20'd0} + 64'(r_c_plo) + 64'd8388608;
        gx       = signed'(DW'(gain_sum >> 24));
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_g.x  <= r_c_flip ? -gx : gx;
            r_g.y  <= '0;
            r_g.zs <= r_c_zs;
            r_g.pu <= r_c_pu;
            r_g.pv <= r_c_pv;
        end
    end

    assign rot_valid[0] = r_g_valid;
    assign rot_data[0]  = r_g;

    for (genvar gj = 0; gj < CORDIC_STAGES; gj++) begin : g_rot
        rpap_rot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_stage (SW'(gj)),
            .i_valid (rot_valid[gj]),
            .i_data  (rot_data[gj]),
            .o_valid (rot_valid[gj+1]),
            .o_data  (rot_data[gj+1])
        );
    end

    // Round off the guard bits, add the pivot back and clamp to 32 bits.
    always_comb begin
        rot_last = rot_data[CORDIC_STAGES];
        xr = (rot_last.x + DW'(8)) >>> GUARD_BITS;
        yr = (rot_last.y + DW'(8)) >>> GUARD_BITS;
        su = 37'(rot_last.pu) + 37'(xr);
        sv = 37'(rot_last.pv) + 37'(yr);
        sat_u = (su > 37'sd2147483647) || (su < -37'sd2147483648);
        sat_v = (sv > 37'sd2147483647) || (sv < -37'sd2147483648);
        if (su > 37'sd2147483647) begin
            n_out.point_u_out = 32'sh7FFF_FFFF;
        end else if (su < -37'sd2147483648) begin
            n_out.point_u_out = 32'sh8000_0000;
        end else begin
            n_out.point_u_out = su[31:0];
        end
        if (sv > 37'sd2147483647) begin
            n_out.point_v_out = 32'sh7FFF_FFFF;
        end else if (sv < -37'sd2147483648) begin
            n_out.point_v_out = 32'sh8000_0000;
        end else begin
            n_out.point_v_out = sv[31:0];
        end
        n_out.saturated = sat_u || sat_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= rot_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;
endmodule

>>> dv/tb_rotate_point_about_pivot_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotate point about pivot: testbench
// Drives rotation requests through the unit under several tolerance settings
// and idle patterns, and checks each response against a bit-true model of the
// two CORDIC chains kept in the testbench or a hand-checked row's own response.
// ----------------------------------------------------------------------------
module tb_rotate_point_about_pivot_unit;
    import rpap_pkg::*;

    localparam int PERIOD_NS     = 8;
    localparam int LATENCY       = 52;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int NUM_PHASES    = 5;
    localparam int N_DIRECTED    = 16;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [19:0] TURN_MAX = 20'sd411775;
    localparam logic signed [19:0] TURN_MIN = -20'sd411775;
    localparam logic signed [19:0] TURN_PI  = 20'sd205887;
    localparam logic signed [19:0] TURN_HALF_PI = 20'sd102944;

    // Arctangent of 2^-i in binary-angle units, 2^32 per turn.
    localparam logic [31:0] ATAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        t_req req;
        logic typed;    // response written out by hand in the row
        t_rsp rsp;
    } t_row;

    // Hand-checked rows use a point on top of its pivot: the distance is zero,
    // so the answer is the pivot itself whatever the turn.
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 20'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
        '{'{S32_MAX, S32_MAX, S32_MAX, S32_MAX, TURN_MAX}, 1'b1,
          '{S32_MAX, S32_MAX, 1'b0}},
        '{'{S32_MIN, S32_MIN, S32_MIN, S32_MIN, TURN_MIN}, 1'b1,
          '{S32_MIN, S32_MIN, 1'b0}},
        '{'{S32_MAX, 32'sd0, S32_MIN, 32'sd0, TURN_HALF_PI}, 1'b0, '0},
        '{'{S32_MIN, S32_MIN, S32_MAX, S32_MAX, 20'sd0}, 1'b0, '0},
        '{'{S32_MAX, S32_MAX, S32_MIN, S32_MIN, TURN_PI}, 1'b0, '0},
        // Vertical offsets, above and below the pivot.
        '{'{32'sd1000, 32'sd0, 32'sd1000, 32'sd655360, TURN_HALF_PI}, 1'b0, '0},
        '{'{32'sd1000, 32'sd0, 32'sd1000, -32'sd655360, TURN_HALF_PI}, 1'b0, '0},
        // Coincidence right at the default tolerance and just past it.
        '{'{32'sd0, 32'sd0, 32'sd66, 32'sd66, TURN_PI}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, 32'sd67, 32'sd0, TURN_PI}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, -32'sd66, 32'sd1000, 20'sd0}, 1'b0, '0},
        '{'{32'sd65536, 32'sd65536, 32'sd131072, 32'sd196608, TURN_MAX}, 1'b0, '0},
        '{'{32'sd65536, 32'sd65536, 32'sd131072, 32'sd196608, TURN_MIN}, 1'b0, '0},
        '{'{-32'sd500000, 32'sd7, -32'sd900000, -32'sd3000000, TURN_PI}, 1'b0, '0},
        // Turning far from the pivot pushes the point out of range.
        '{'{S32_MAX, 32'sd0, 32'sd0, 32'sd0, TURN_PI}, 1'b0, '0},
        '{'{S32_MIN, 32'sd12345, 32'sd0, -32'sd99999, TURN_PI}, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req;
    logic        o_rsp_valid;
    logic        i_rsp_ready;
    t_rsp        o_rsp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    rotate_point_about_pivot_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Testbench copy of the tolerance register, updated on each accepted write.
    logic [15:0] tolerance;
    t_rsp        pending_rsp[$];
    int          errors;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    logic        hold_toggle;
    logic        row_typed;
    t_rsp        row_rsp;

    initial begin
        i_clk = 1'b0;
        forever #(PERIOD_NS / 2) i_clk = ~i_clk;
    end

    // Vectoring CORDIC for distance and polar angle, polar-angle selection,
    // then a rotation CORDIC of the gain-corrected distance by polar + turn.
    function automatic t_rsp rotate_about_pivot(input t_req r, input logic [15:0] tol);
        longint      pu, pv, du, dv, x, y, nx, mag, zs, ou, ov, turn, tl;
        logic [31:0] z, polar, phi, turn_bin;
        logic        clamp;
        t_rsp        res;
        pu = longint'(r.pivot_u);
        pv = longint'(r.pivot_v);
        du = longint'(r.point_u_in) - pu;
        dv = longint'(r.point_v_in) - pv;
        turn = longint'(r.turn_angle);
        tl = longint'(tol);
        x = du * 16;
        y = dv * 16;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_STEP[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_STEP[i];
            end
            x = nx;
        end
        mag = x;

        if ((du <= tl && -du <= tl) && (dv <= tl && -dv <= tl))
            polar = '0;
        else if (du <= tl && -du <= tl)
            polar = (dv > 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
        else
            polar = z;

        turn_bin = 32'((turn * 64'sd683565276 + 64'sd32768) >>> FRACTION_BITS);
        phi = polar + turn_bin;

        // Scale the vectoring magnitude K*r by 1/K^2 to start at r/K, so the rotation gain brings it back to r.
        x = (mag * 64'sd6186701 + 64'sd8388608) >>> 24;
        y = 0;
        if (((phi + QUARTER_TURN) & HALF_TURN) != 0) begin
            x   = -x;
            phi = phi - HALF_TURN;
        end
        zs = (phi >= HALF_TURN) ? longint'(phi) - 64'sd4294967296 : longint'(phi);
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (zs >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                zs = zs - longint'(ATAN_STEP[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                zs = zs + longint'(ATAN_STEP[i]);
            end
            x = nx;
        end

        clamp = 1'b0;
        ou = pu + ((x + 8) >>> GUARD_BITS);
        ov = pv + ((y + 8) >>> GUARD_BITS);
        if (ou > 64'sd2147483647) begin ou = 64'sd2147483647; clamp = 1'b1; end
        if (ou < -64'sd2147483648) begin ou = -64'sd2147483648; clamp = 1'b1; end
        if (ov > 64'sd2147483647) begin ov = 64'sd2147483647; clamp = 1'b1; end
        if (ov < -64'sd2147483648) begin ov = -64'sd2147483648; clamp = 1'b1; end
        res.point_u_out = ou[31:0];
        res.point_v_out = ov[31:0];
        res.saturated   = clamp;
        return res;
    endfunction

    // Accepted requests, responses and register writes, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_req_valid && o_req_ready) begin
            if (row_typed)
                pending_rsp.push_back(row_rsp);
            else
                pending_rsp.push_back(rotate_about_pivot(i_req, tolerance));
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            tolerance <= i_cfg_data;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with nothing outstanding: u=%h v=%h sat=%b",
                         $time, o_rsp.point_u_out, o_rsp.point_v_out, o_rsp.saturated);
                errors++;
            end else begin
                if (o_rsp.point_u_out !== pending_rsp[0].point_u_out) begin
                    $display("%0t: point_u_out expected %h actual %h", $time,
                             pending_rsp[0].point_u_out, o_rsp.point_u_out);
                    errors++;
                end
                if (o_rsp.point_v_out !== pending_rsp[0].point_v_out) begin
                    $display("%0t: point_v_out expected %h actual %h", $time,
                             pending_rsp[0].point_v_out, o_rsp.point_v_out);
                    errors++;
                end
                if (o_rsp.saturated !== pending_rsp[0].saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             pending_rsp[0].saturated, o_rsp.saturated);
                    errors++;
                end
                void'(pending_rsp.pop_front());
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the driver asks.
    // The hold is counted here so the sender keeps offering requests meanwhile.
    logic hold_seen;
    int   hold_left;
    always @(negedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen   <= hold_toggle;
            hold_left   <= HOLD_CYCLES;
            i_rsp_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: a long run of cycles with no handshake of any kind means a hang.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Presents one request and returns at the falling edge after it is taken.
    task automatic send_request(input t_req r, input logic typed, input t_rsp rsp);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        row_typed   <= typed;
        row_rsp     <= rsp;
        @(posedge i_clk);
        while (!o_req_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Waits out every outstanding response, then the pipeline depth, so a
    // register write lands on an empty unit.
    task automatic drain();
        i_req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random request about a random pivot: offsets of a random power-of-two span,
    // fully random coordinates, offsets near the tolerance and points on the pivot.
    function automatic t_req random_request(input logic [15:0] tol);
        t_req r;
        int   mode;
        int   span;
        mode = $urandom_range(99);
        r.pivot_u    = $urandom;
        r.pivot_v    = $urandom;
        r.turn_angle = 20'($signed($urandom_range(823550)) - 411775);
        if (mode < 25) begin
            r.point_u_in = $urandom;
            r.point_v_in = $urandom;
        end else if (mode < 70) begin
            span = 1 << $urandom_range(4, 30);
            r.point_u_in = r.pivot_u + $signed($urandom_range(span)) - span / 2;
            r.point_v_in = r.pivot_v + $signed($urandom_range(span)) - span / 2;
        end else if (mode < 85) begin
            r.point_u_in = r.pivot_u + $signed($urandom_range(2 * tol + 2)) - tol - 1;
            r.point_v_in = r.pivot_v + $signed($urandom_range(4000000)) - 2000000;
        end else if (mode < 95) begin
            r.point_u_in = r.pivot_u + $signed($urandom_range(2 * tol + 2)) - tol - 1;
            r.point_v_in = r.pivot_v + $signed($urandom_range(2 * tol + 2)) - tol - 1;
        end else begin
            r.point_u_in = r.pivot_u;
            r.point_v_in = r.pivot_v;
        end
        return r;
    endfunction

    initial begin
        logic [15:0] phase_tol [NUM_PHASES];
        int          phase_idle [NUM_PHASES];
        int          phase_stall [NUM_PHASES];
        phase_tol   = '{16'd0, 16'd65535, 16'd66, 16'd1, 16'd0};
        phase_idle  = '{0, 60, 0, 11, 0};
        phase_stall = '{0, 0, 60, 11, 0};
        phase_tol[4] = 16'($urandom);

        i_rst_n            = 1'b0;
        i_req_valid        = 1'b0;
        i_req              = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_data         = '0;
        i_rsp_ready        = 1'b0;
        hold_toggle        = 1'b0;
        hold_seen          = 1'b0;
        hold_left          = 0;
        row_typed          = 1'b0;
        row_rsp            = '0;
        tolerance          = 16'd66;
        errors             = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows run with the reset value of the tolerance.
        for (int k = 0; k < N_DIRECTED; k++)
            send_request(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].rsp);
        row_typed <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_tolerance(phase_tol[p]);
            sender_idle_pct    = phase_idle[p];
            receiver_stall_pct = phase_stall[p];
            // In the first phase the receiver holds off for a long stretch so
            // the pipeline fills and back-pressures the request side.
            if (p == 0)
                hold_toggle <= ~hold_toggle;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_request(random_request(phase_tol[p]), 1'b0, '0);
        end

        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/rpap_pkg.sv
rtl/rpap_vec_cell.sv
rtl/rpap_rot_cell.sv
rtl/rotate_point_about_pivot_unit.sv
dv/tb_rotate_point_about_pivot_unit.sv
